>>> src/rsd_pkg.sv
// shared constants, types and helpers of the route segment densifier
package rsd_pkg;

  localparam int ROUTE_DEPTH = 1024;
  localparam int MAX_STEPS   = 64;

  localparam int COORD_W = 32;
  localparam int MAG_W   = COORD_W + 1;
  localparam int PROD_W  = 2 * MAG_W;
  localparam int CNT_W   = $clog2(ROUTE_DEPTH + 1);
  localparam int IDX_W   = 10;
  localparam int STEP_W  = $clog2(MAX_STEPS + 1);
  localparam int DIVD_W  = MAG_W + STEP_W;
  localparam int ROOT_W  = PROD_W / 2;
  localparam int CFG_W   = 31;
  localparam int CAP_W   = 11;

  typedef enum logic [1:0] {
    ACT_APPEND  = 2'd0,
    ACT_REPLACE = 2'd1,
    ACT_DROP    = 2'd2
  } action_t;

  typedef enum logic [1:0] {
    REG_MERGE_RADIUS = 2'd0,
    REG_STEP_LIMIT   = 2'd1,
    REG_CAPACITY     = 2'd2
  } cfg_reg_t;

  // magnitude of a signed difference
  function automatic logic [MAG_W-1:0] mag(input logic signed [MAG_W-1:0] v);
    mag = v[MAG_W-1] ? MAG_W'(-v) : MAG_W'(v);
  endfunction

endpackage

>>> src/rsd_mul.sv
// shared unsigned multiplier with registered product
module rsd_mul (
  input  logic                        clk,
  input  logic [rsd_pkg::MAG_W-1:0]   a,
  input  logic [rsd_pkg::MAG_W-1:0]   b,
  output logic [rsd_pkg::PROD_W-1:0]  p
);
  import rsd_pkg::*;

  // one product per cycle, result available in the next cycle
  always_ff @(posedge clk) begin
    p <= PROD_W'(a) * PROD_W'(b);
  end

endmodule

>>> src/rsd_div.sv
// restoring divider, one quotient bit per cycle
module rsd_div (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [rsd_pkg::DIVD_W-1:0]  dividend,
  input  logic [rsd_pkg::STEP_W-1:0]  divisor,
  output logic                        done,
  output logic [rsd_pkg::DIVD_W-1:0]  quotient
);
  import rsd_pkg::*;

  localparam int CW = $clog2(DIVD_W);

  logic              busy;
  logic [CW-1:0]     cnt;
  logic [STEP_W-1:0] rem;
  logic [STEP_W-1:0] dv;
  logic [STEP_W:0]   rem_sh;

  assign rem_sh = {rem, quotient[DIVD_W-1]};

  // shift in one dividend bit, subtract when it fits
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy     <= 1'b1;
        quotient <= dividend;
        rem      <= '0;
        dv       <= divisor;
        cnt      <= CW'(DIVD_W - 1);
      end else if (busy) begin
        if (rem_sh >= {1'b0, dv}) begin
          rem      <= STEP_W'(rem_sh - {1'b0, dv});
          quotient <= {quotient[DIVD_W-2:0], 1'b1};
        end else begin
          rem      <= rem_sh[STEP_W-1:0];
          quotient <= {quotient[DIVD_W-2:0], 1'b0};
        end
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          cnt <= cnt - 1'b1;
        end
      end
    end
  end

endmodule

>>> src/rsd_sqrt.sv
// bit-serial integer square root, two radicand bits per cycle
module rsd_sqrt (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [rsd_pkg::PROD_W-1:0]  radicand,
  output logic                        done,
  output logic [rsd_pkg::ROOT_W-1:0]  root,
  output logic                        rem_nz
);
  import rsd_pkg::*;

  localparam int CW  = $clog2(ROOT_W);
  localparam int RW  = ROOT_W + 3;

  logic              busy;
  logic [CW-1:0]     cnt;
  logic [PROD_W-1:0] rad;
  logic [RW-1:0]     rem;
  logic [RW-1:0]     rem_sh;
  logic [RW-1:0]     trial;

  assign rem_sh = {rem[RW-3:0], rad[PROD_W-1 -: 2]};
  assign trial  = RW'({root, 2'b01});
  assign rem_nz = (rem != '0);

  // one root bit per cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        rad  <= radicand;
        rem  <= '0;
        root <= '0;
        cnt  <= CW'(ROOT_W - 1);
      end else if (busy) begin
        rad <= {rad[PROD_W-3:0], 2'b00};
        if (rem_sh >= trial) begin
          rem  <= rem_sh - trial;
          root <= {root[ROOT_W-2:0], 1'b1};
        end else begin
          rem  <= rem_sh;
          root <= {root[ROOT_W-2:0], 1'b0};
        end
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          cnt <= cnt - 1'b1;
        end
      end
    end
  end

endmodule

>>> src/route_segment_densifier.sv
// top level: sequencer of the route segment densifier
//
// Input items arrive on the s_axis channel: tuser selects a single point (0)
// or a segment (1), tdata carries from_x, from_y, to_x, to_y. Each point
// offered to the route yields one result item on m_axis: tdata holds the
// route index and the point, tuser the action, tlast marks the final result
// of an input item. A segment item while step_limit is zero yields nothing.
// Registers are written through cfg_valid/cfg_index/cfg_data, always ready.
// One input item is taken at a time; s_axis_tready is high only when idle.
// A point skips the distance check when the route is empty or full. A
// segment finds its length with the multiplier and a 33-step square root,
// then searches for its step count; each step point is set by two passes
// of the 40-step divider and the shared multiplier.
// A result waits in the output register while m_axis_tready is low and the
// sequencer holds until it is taken; the next input may be accepted while
// the final result is still waiting. Reset empties the route, drops any
// pending result and restores the register defaults.
module route_segment_densifier (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [127:0] s_axis_tdata,  // from_x, from_y, to_x, to_y
  input  logic [0:0]   s_axis_tuser,  // operation
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [79:0]  m_axis_tdata,  // route_index, point_x, point_y, zero pad
  output logic [1:0]   m_axis_tuser,  // action
  output logic         m_axis_tlast,  // last_in_run
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [1:0]   cfg_index,
  input  logic [30:0]  cfg_data
);
  import rsd_pkg::*;

  typedef enum logic [17:0] {
    S_IDLE   = 18'h00001,
    S_SQX    = 18'h00002,
    S_SQY    = 18'h00004,
    S_SUM    = 18'h00008,
    S_SQRT   = 18'h00010,
    S_STEPS  = 18'h00020,
    S_XMUL   = 18'h00040,
    S_XDIVGO = 18'h00080,
    S_XDIV   = 18'h00100,
    S_YMUL   = 18'h00200,
    S_YDIVGO = 18'h00400,
    S_YDIV   = 18'h00800,
    S_OFFER  = 18'h01000,
    S_DSQX   = 18'h02000,
    S_DSQY   = 18'h04000,
    S_DSQM   = 18'h08000,
    S_DCMP   = 18'h10000,
    S_EMIT   = 18'h20000
  } state_t;

  localparam int T_W = CFG_W + STEP_W;

  state_t state;

  logic [CFG_W-1:0] merge_radius;
  logic [CFG_W-1:0] step_limit;
  logic [CAP_W-1:0] capacity;

  logic [CNT_W-1:0]          count;
  logic signed [COORD_W-1:0] last_x, last_y;

  logic                      op_seg;
  logic signed [COORD_W-1:0] fx, fy, px, py;
  logic signed [MAG_W-1:0]   dxs, dys;
  logic [PROD_W-1:0]         acc;
  logic [ROOT_W:0]           rootc;
  logic [T_W-1:0]            t;
  logic [STEP_W-1:0]         s, steps, i;
  action_t                   act;
  logic [IDX_W-1:0]          idx;

  logic [MAG_W-1:0]  mul_a, mul_b;
  logic [PROD_W-1:0] mul_p;
  logic              div_start, div_done;
  logic [DIVD_W-1:0] quo;
  logic              sqrt_done, sqrt_nz;
  logic [ROOT_W-1:0] root;

  logic signed [MAG_W-1:0]   ddx, ddy;
  logic signed [MAG_W:0]     qs;
  logic [CNT_W-1:0]          limit;
  logic                      slot_free;
  logic                      in_acc;
  logic                      last_res;

  assign cfg_ready     = 1'b1;
  assign s_axis_tready = (state == S_IDLE);
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign slot_free     = !m_axis_tvalid || m_axis_tready;
  assign last_res      = !op_seg || (i == steps);

  assign ddx   = MAG_W'(last_x) - MAG_W'(px);
  assign ddy   = MAG_W'(last_y) - MAG_W'(py);
  assign limit = (capacity < CNT_W'(ROUTE_DEPTH)) ? capacity : CNT_W'(ROUTE_DEPTH);

  // signed quotient of the divider for the current axis
  always_comb begin
    if ((state == S_XDIV && dxs[MAG_W-1]) || (state == S_YDIV && dys[MAG_W-1])) begin
      qs = -$signed({1'b0, quo[MAG_W-1:0]});
    end else begin
      qs = $signed({1'b0, quo[MAG_W-1:0]});
    end
  end

  // multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state)
      S_SQX:   begin mul_a = mag(dxs); mul_b = mag(dxs); end
      S_SQY:   begin mul_a = mag(dys); mul_b = mag(dys); end
      S_XMUL:  begin mul_a = mag(dxs); mul_b = MAG_W'(i); end
      S_YMUL:  begin mul_a = mag(dys); mul_b = MAG_W'(i); end
      S_DSQX:  begin mul_a = mag(ddx); mul_b = mag(ddx); end
      S_DSQY:  begin mul_a = mag(ddy); mul_b = mag(ddy); end
      S_DSQM:  begin mul_a = MAG_W'(merge_radius); mul_b = MAG_W'(merge_radius); end
      default: begin mul_a = '0; mul_b = '0; end
    endcase
  end

  assign div_start = (state == S_XDIVGO) || (state == S_YDIVGO);

  rsd_mul u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .p   (mul_p)
  );

  rsd_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (mul_p[DIVD_W-1:0]),
    .divisor  (steps),
    .done     (div_done),
    .quotient (quo)
  );

  rsd_sqrt u_sqrt (
    .clk      (clk),
    .rst      (rst),
    .start    (state == S_SUM),
    .radicand (acc + mul_p),
    .done     (sqrt_done),
    .root     (root),
    .rem_nz   (sqrt_nz)
  );

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      merge_radius <= '0;
      step_limit   <= CFG_W'(65536);
      capacity     <= CAP_W'(ROUTE_DEPTH);
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_MERGE_RADIUS: merge_radius <= cfg_data;
        REG_STEP_LIMIT:   step_limit   <= cfg_data;
        REG_CAPACITY:     capacity     <= cfg_data[CAP_W-1:0];
        default:          ;
      endcase
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      count         <= '0;
      last_x        <= '0;
      last_y        <= '0;
      m_axis_tvalid <= 1'b0;
    end else begin
      // result register: load on emit, clear once taken
      if (state == S_EMIT && slot_free) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_acc) begin
            fx  <= s_axis_tdata[31:0];
            fy  <= s_axis_tdata[63:32];
            px  <= s_axis_tdata[95:64];
            py  <= s_axis_tdata[127:96];
            dxs <= MAG_W'($signed(s_axis_tdata[95:64])) - MAG_W'($signed(s_axis_tdata[31:0]));
            dys <= MAG_W'($signed(s_axis_tdata[127:96])) - MAG_W'($signed(s_axis_tdata[63:32]));
            op_seg <= s_axis_tuser[0];
            if (!s_axis_tuser[0]) state <= S_OFFER;
            else if (step_limit != '0) state <= S_SQX;
          end
        end
        S_SQX: state <= S_SQY;
        S_SQY: begin
          acc   <= mul_p;
          state <= S_SUM;
        end
        S_SUM: state <= S_SQRT;
        S_SQRT: begin
          if (sqrt_done) begin
            rootc <= {1'b0, root} + (ROOT_W+1)'(sqrt_nz);
            t     <= T_W'(step_limit);
            s     <= STEP_W'(1);
            state <= S_STEPS;
          end
        end
        // least step count whose total length covers the segment, capped at MAX_STEPS
        S_STEPS: begin
          if (s == STEP_W'(MAX_STEPS) || t >= T_W'(rootc)) begin
            steps <= s;
            i     <= STEP_W'(1);
            state <= S_XMUL;
          end else begin
            t <= t + T_W'(step_limit);
            s <= s + 1'b1;
          end
        end
        S_XMUL:   state <= S_XDIVGO;
        S_XDIVGO: state <= S_XDIV;
        S_XDIV: begin
          if (div_done) begin
            px    <= COORD_W'((MAG_W+1)'(fx) + qs);
            state <= S_YMUL;
          end
        end
        S_YMUL:   state <= S_YDIVGO;
        S_YDIVGO: state <= S_YDIV;
        S_YDIV: begin
          if (div_done) begin
            py    <= COORD_W'((MAG_W+1)'(fy) + qs);
            state <= S_OFFER;
          end
        end
        // add rule: drop if full, else first point appends, else near one replaces
        S_OFFER: begin
          if (count >= limit) begin
            act   <= ACT_DROP;
            idx   <= (count > CNT_W'(1023)) ? IDX_W'(1023) : count[IDX_W-1:0];
            state <= S_EMIT;
          end else if (count == '0) begin
            act   <= ACT_APPEND;
            idx   <= '0;
            state <= S_EMIT;
          end else begin
            state <= S_DSQX;
          end
        end
        S_DSQX: state <= S_DSQY;
        S_DSQY: begin
          acc   <= mul_p;
          state <= S_DSQM;
        end
        S_DSQM: begin
          acc   <= acc + mul_p;
          state <= S_DCMP;
        end
        S_DCMP: begin
          if (acc < mul_p) begin
            act <= ACT_REPLACE;
            idx <= IDX_W'(count - 1'b1);
          end else begin
            act <= ACT_APPEND;
            idx <= count[IDX_W-1:0];
          end
          state <= S_EMIT;
        end
        // load the result and commit the route update
        S_EMIT: begin
          if (slot_free) begin
            m_axis_tdata  <= {6'd0, py, px, idx};
            m_axis_tuser  <= act;
            m_axis_tlast  <= last_res;
            if (act != ACT_DROP) begin
              last_x <= px;
              last_y <= py;
            end
            if (act == ACT_APPEND) count <= count + 1'b1;
            if (last_res) begin
              state <= S_IDLE;
            end else begin
              i     <= i + 1'b1;
              state <= S_XMUL;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // route never grows past its depth
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(ROUTE_DEPTH))
    else $error("route count beyond depth");

  // an appended entry is the newest one in the route
  a_append_idx: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tuser == ACT_APPEND) |->
      m_axis_tdata[IDX_W-1:0] == IDX_W'(count - 1'b1))
    else $error("append index does not match route count");

  // no action code outside the three kinds
  a_action_code: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (m_axis_tuser == ACT_APPEND || m_axis_tuser == ACT_REPLACE ||
                       m_axis_tuser == ACT_DROP))
    else $error("bad action code");

  // nothing pending right after reset
  a_reset_clear: assert property (@(posedge clk)
    $past(rst) |-> (!m_axis_tvalid && s_axis_tready))
    else $error("result or work left after reset");

endmodule
